[design/gpio_port_register_bank_macros.svh]
// assertion macros for the gpio port register bank checker
`ifndef GPIO_PORT_REGISTER_BANK_MACROS_SVH
`define GPIO_PORT_REGISTER_BANK_MACROS_SVH

// same-cycle implication, disabled in reset
`define GPB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GPB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gpb_pkg.sv]
// shared types, constants and helpers of the gpio port register bank
package gpb_pkg;

  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 104;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_WIDTH    = 2'd2;

  localparam logic [6:0] OUT_BASE = 7'h10;
  localparam logic [6:0] IN_OFF   = 7'h20;
  localparam logic [6:0] WORD_END = 7'h2C;
  localparam logic [6:0] MUX_BASE = 7'h30;
  localparam logic [6:0] CFG_BASE = 7'h40;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_DIR,
    SEL_OUT,
    SEL_IN,
    SEL_MUX,
    SEL_CFG
  } sel_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CLR,
    OP_SET,
    OP_TGL
  } op_t;

  typedef struct packed {
    logic [1:0] status;
    sel_t       sel;
    op_t        op;
    logic       wr;
  } dec_t;

  function automatic logic [31:0] apply_op(op_t op, logic [31:0] cur, logic [31:0] data,
                                           logic [31:0] mask);
    logic [31:0] res;
    case (op)
      OP_WRITE: res = data & mask;
      OP_CLR:   res = cur & ~data;
      OP_SET:   res = cur | (data & mask);
      OP_TGL:   res = cur ^ (data & mask);
      default:  res = cur;
    endcase
    return res & mask;
  endfunction

endpackage

[design/gpb_ram.sv]
// generic single-port-write ram with registered read
module gpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/gpb_decode.sv]
// offset and width decode of one register access
module gpb_decode import gpb_pkg::*; #(
  parameter int GROUPS         = 2,
  parameter int PINS_PER_GROUP = 32,
  parameter int MUX_AW         = 5,
  parameter int CFG_AW         = 6
) (
  input  logic              cmd,
  input  logic              word_access,
  input  logic              group_sel,
  input  logic [6:0]        reg_offset,
  output dec_t              dec,
  output logic [MUX_AW-1:0] mux_addr,
  output logic [CFG_AW-1:0] cfg_addr
);

  localparam int MUX_BYTES = (PINS_PER_GROUP + 1) / 2;
  localparam logic [6:0] MUX_END = 7'(int'(MUX_BASE) + MUX_BYTES);
  localparam logic [6:0] CFG_END = 7'(int'(CFG_BASE) + PINS_PER_GROUP);

  assign mux_addr = MUX_AW'(int'(group_sel) * MUX_BYTES + int'(reg_offset - MUX_BASE));
  assign cfg_addr = CFG_AW'(int'(group_sel) * PINS_PER_GROUP + int'(reg_offset - CFG_BASE));

  always_comb begin
    dec.wr     = cmd;
    dec.op     = op_t'(reg_offset[3:2]);
    dec.sel    = SEL_NONE;
    dec.status = ST_OK;
    if (int'(group_sel) >= GROUPS) begin
      dec.status = ST_UNMAPPED;
    end else if (reg_offset < WORD_END) begin
      if (!word_access) begin
        dec.status = ST_WIDTH;
      end else if (reg_offset[1:0] != 2'b00) begin
        dec.status = ST_UNMAPPED;
      end else if (reg_offset < OUT_BASE) begin
        dec.sel = SEL_DIR;
      end else if (reg_offset < IN_OFF) begin
        dec.sel = SEL_OUT;
      end else if (reg_offset == IN_OFF) begin
        dec.sel = SEL_IN;
      end
    end else if (reg_offset >= MUX_BASE && reg_offset < MUX_END) begin
      if (word_access) begin
        dec.status = ST_WIDTH;
      end else begin
        dec.sel = SEL_MUX;
      end
    end else if (reg_offset >= CFG_BASE && reg_offset < CFG_END) begin
      if (word_access) begin
        dec.status = ST_WIDTH;
      end else begin
        dec.sel = SEL_CFG;
      end
    end else begin
      dec.status = ST_UNMAPPED;
    end
  end

endmodule

[design/gpio_port_register_bank.sv]
// gpio port register bank: direction/output write/set/clear/toggle registers, input levels and byte areas
// an accepted item is registered in the input stage, then in the result register
// throughput: one item per cycle unless out_tready stalls; the byte-area rams give one read and one write a cycle
// a write followed at once by a read of the same byte is forwarded around the ram
// reset: direction and output registers clear, byte-area valid bits clear so
// never-written bytes read as zero; no clearing pass, items accepted right after reset
module gpio_port_register_bank import gpb_pkg::*; #(
  parameter int GROUPS         = 2,
  parameter int PINS_PER_GROUP = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // group, reg_offset, write_data, pin_levels
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd, word_access
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_data, status, dir_drive, out_drive, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int MUX_BYTES = (PINS_PER_GROUP + 1) / 2;
  localparam int MUX_DEPTH = GROUPS * MUX_BYTES;
  localparam int CFG_DEPTH = GROUPS * PINS_PER_GROUP;
  localparam int MUX_AW    = MUX_DEPTH > 1 ? $clog2(MUX_DEPTH) : 1;
  localparam int CFG_AW    = CFG_DEPTH > 1 ? $clog2(CFG_DEPTH) : 1;
  localparam logic [31:0] PIN_MASK = 32'((64'd1 << PINS_PER_GROUP) - 64'd1);

  // input unpack
  logic        in_cmd;
  logic        in_word;
  logic        in_grp;
  logic [6:0]  in_off;
  logic [31:0] in_wdata;
  logic [31:0] in_lvl;

  assign in_cmd   = in_tuser[0];
  assign in_word  = in_tuser[1];
  assign in_grp   = in_tdata[0];
  assign in_off   = in_tdata[7:1];
  assign in_wdata = in_tdata[39:8];
  assign in_lvl   = in_tdata[71:40];

  dec_t              in_dec;
  logic [MUX_AW-1:0] in_mux_addr;
  logic [CFG_AW-1:0] in_cfg_addr;

  gpb_decode #(
    .GROUPS         (GROUPS),
    .PINS_PER_GROUP (PINS_PER_GROUP),
    .MUX_AW         (MUX_AW),
    .CFG_AW         (CFG_AW)
  ) u_decode (
    .cmd         (in_cmd),
    .word_access (in_word),
    .group_sel   (in_grp),
    .reg_offset  (in_off),
    .dec         (in_dec),
    .mux_addr    (in_mux_addr),
    .cfg_addr    (in_cfg_addr)
  );

  // stage registers
  logic              s1_vld_r;
  dec_t              s1_dec_r;
  logic              s1_grp_r;
  logic [31:0]       s1_wdata_r;
  logic [31:0]       s1_lvl_r;
  logic [MUX_AW-1:0] s1_mux_addr_r;
  logic [CFG_AW-1:0] s1_cfg_addr_r;
  logic              s1_byp_r;
  logic [7:0]        s1_byp_data_r;
  logic              byp_nxt;

  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  logic [31:0] dir_r [GROUPS];
  logic [31:0] outl_r [GROUPS];
  logic        mux_vld_r [MUX_DEPTH];
  logic        cfg_vld_r [CFG_DEPTH];

  logic in_acc;
  logic s1_go;

  assign s1_go     = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  // update logic
  logic        wr_ok;
  logic        mux_we;
  logic        cfg_we;
  logic [7:0]  mux_rdata;
  logic [7:0]  cfg_rdata;
  logic [7:0]  mux_byte;
  logic [7:0]  cfg_byte;
  logic [31:0] dir_cur;
  logic [31:0] out_cur;
  logic [31:0] dir_nxt;
  logic [31:0] outl_nxt;
  logic [31:0] rd;

  assign wr_ok  = s1_dec_r.wr && (s1_dec_r.status == ST_OK);
  assign mux_we = s1_go && wr_ok && (s1_dec_r.sel == SEL_MUX);
  assign cfg_we = s1_go && wr_ok && (s1_dec_r.sel == SEL_CFG);

  assign byp_nxt = s1_go && wr_ok &&
                   (((s1_dec_r.sel == SEL_MUX) && (in_dec.sel == SEL_MUX) &&
                     (s1_mux_addr_r == in_mux_addr)) ||
                    ((s1_dec_r.sel == SEL_CFG) && (in_dec.sel == SEL_CFG) &&
                     (s1_cfg_addr_r == in_cfg_addr)));

  gpb_ram #(.WIDTH(8), .DEPTH(MUX_DEPTH)) u_mux_ram (
    .clk   (clk),
    .we    (mux_we),
    .waddr (s1_mux_addr_r),
    .wdata (s1_wdata_r[7:0]),
    .re    (in_acc),
    .raddr (in_mux_addr),
    .rdata (mux_rdata)
  );

  gpb_ram #(.WIDTH(8), .DEPTH(CFG_DEPTH)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (s1_cfg_addr_r),
    .wdata (s1_wdata_r[7:0]),
    .re    (in_acc),
    .raddr (in_cfg_addr),
    .rdata (cfg_rdata)
  );

  always_comb begin
    dir_cur = '0;
    out_cur = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (int'(s1_grp_r) == g) begin
        dir_cur = dir_r[g];
        out_cur = outl_r[g];
      end
    end
  end

  always_comb begin
    mux_byte = s1_byp_r ? s1_byp_data_r : (mux_vld_r[s1_mux_addr_r] ? mux_rdata : 8'd0);
    cfg_byte = s1_byp_r ? s1_byp_data_r : (cfg_vld_r[s1_cfg_addr_r] ? cfg_rdata : 8'd0);
    dir_nxt  = (wr_ok && s1_dec_r.sel == SEL_DIR) ?
               apply_op(s1_dec_r.op, dir_cur, s1_wdata_r, PIN_MASK) : dir_cur;
    outl_nxt = (wr_ok && s1_dec_r.sel == SEL_OUT) ?
               apply_op(s1_dec_r.op, out_cur, s1_wdata_r, PIN_MASK) : out_cur;
    case (s1_dec_r.sel)
      SEL_DIR: rd = dir_cur;
      SEL_OUT: rd = out_cur;
      SEL_IN:  rd = s1_lvl_r & PIN_MASK;
      SEL_MUX: rd = {24'd0, mux_byte};
      SEL_CFG: rd = {24'd0, cfg_byte};
      default: rd = '0;
    endcase
    if (s1_dec_r.wr || s1_dec_r.status != ST_OK) begin
      rd = '0;
    end
    out_data_nxt = {6'd0, outl_nxt, dir_nxt, s1_dec_r.status, rd};
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        dir_r[g]  <= '0;
        outl_r[g] <= '0;
      end
      for (int i = 0; i < MUX_DEPTH; i++) begin
        mux_vld_r[i] <= 1'b0;
      end
      for (int i = 0; i < CFG_DEPTH; i++) begin
        cfg_vld_r[i] <= 1'b0;
      end
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (s1_go) begin
        out_vld_r <= 1'b1;
        for (int g = 0; g < GROUPS; g++) begin
          if (int'(s1_grp_r) == g) begin
            dir_r[g]  <= dir_nxt;
            outl_r[g] <= outl_nxt;
          end
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (mux_we) begin
        mux_vld_r[s1_mux_addr_r] <= 1'b1;
      end
      if (cfg_we) begin
        cfg_vld_r[s1_cfg_addr_r] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_dec_r      <= in_dec;
      s1_grp_r      <= in_grp;
      s1_wdata_r    <= in_wdata;
      s1_lvl_r      <= in_lvl;
      s1_mux_addr_r <= in_mux_addr;
      s1_cfg_addr_r <= in_cfg_addr;
      s1_byp_r      <= byp_nxt;
      s1_byp_data_r <= s1_wdata_r[7:0];
    end
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

[design/gpb_checker.sv]
// port-level checker for the gpio port register bank, with its bind
`include "gpio_port_register_bank_macros.svh"

module gpb_checker import gpb_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `GPB_ASSERT_IMP(a_status_code, out_tvalid, out_tdata[33:32] == ST_OK || out_tdata[33:32] == ST_UNMAPPED || out_tdata[33:32] == ST_WIDTH, "gpb: bad status code")
  `GPB_ASSERT_IMP(a_err_zero_read, out_tvalid && out_tdata[33:32] != ST_OK, out_tdata[31:0] == 32'd0, "gpb: failed access returned data")
  `GPB_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "gpb: stalled result changed")

endmodule

bind gpio_port_register_bank gpb_checker u_gpb_checker (.*);
